>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// condition must never be seen
`define ASSERT_NEVER(label, cond, msg) \
   `ASSERT_ALWAYS(label, !(cond), msg)

`endif

>>> hdl/rlhs_pkg.sv
// ----------------------------------------------------------------------------
// rlhs_pkg
// shared types and constants of the luma histogram stretch core
// ----------------------------------------------------------------------------
package rlhs_pkg;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_MEASURE = 2'd1,
      CMD_STRETCH = 2'd2,
      CMD_UNUSED  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV_INEW,
      BK_DIV_RED,
      BK_DIV_GREEN,
      BK_DIV_BLUE,
      BK_RESULT
   } back_state_type;

   // luma weights, scaled by 1000
   localparam int          LUMA_SUM_W   = 18;
   localparam logic [17:0] WEIGHT_RED   = 18'd299;
   localparam logic [17:0] WEIGHT_GREEN = 18'd587;
   localparam logic [17:0] WEIGHT_BLUE  = 18'd114;

   // floor(sum / 1000) as (sum * ceil(2^28 / 1000)) >> 28, exact for sum < 2^18
   localparam int          RECIP_W     = 19;
   localparam logic [18:0] RECIP_1000  = 19'd268436;
   localparam int          RECIP_SHIFT = 28;
   localparam int          LUMA_PROD_W = LUMA_SUM_W + RECIP_W;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = QPTR_W + 1;

   // shared divider: 16 bit dividend, 8 bit divisor, two quotient bits a cycle
   localparam int DIVIDEND_W = 16;
   localparam int DIVISOR_W  = 8;
   localparam int DIV_RADIX  = 2;
   localparam int DIV_STEPS  = DIVIDEND_W / DIV_RADIX;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   localparam logic [7:0] PIXEL_MAX = 8'hFF;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] luma;
   } item_type;

   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

>>> hdl/rlhs_front.sv
// ----------------------------------------------------------------------------
// rlhs_front
// accepts words, forms the luma and pushes classified items into the queue
// ----------------------------------------------------------------------------
module rlhs_front
   import rlhs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   input  logic       q_full,
   output logic       q_push,
   output item_type   q_item
);

   logic                   stage_valid_ff, stage_valid_in;
   cmd_type                cmd_ff;
   logic [7:0]             red_ff, green_ff, blue_ff;
   logic [LUMA_SUM_W-1:0]  sum_ff, sum_in;
   logic [LUMA_PROD_W-1:0] luma_prod;
   logic                   accept, drain;

   assign drain     = stage_valid_ff && !q_full;
   assign req_stall = stage_valid_ff && !drain;
   assign accept    = req_valid && !req_stall;

   // unused command code is dropped here
   assign stage_valid_in = (accept && (cmd_type'(req_command) != CMD_UNUSED))
                           || (stage_valid_ff && !drain);

   assign sum_in = {10'd0, req_red}   * WEIGHT_RED
                 + {10'd0, req_green} * WEIGHT_GREEN
                 + {10'd0, req_blue}  * WEIGHT_BLUE;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff   <= cmd_type'(req_command);
         red_ff   <= req_red;
         green_ff <= req_green;
         blue_ff  <= req_blue;
         sum_ff   <= sum_in;
      end
   end

   assign luma_prod = {{RECIP_W{1'b0}}, sum_ff} * {{LUMA_SUM_W{1'b0}}, RECIP_1000};

   assign q_push       = drain;
   assign q_item.cmd   = cmd_ff;
   assign q_item.red   = red_ff;
   assign q_item.green = green_ff;
   assign q_item.blue  = blue_ff;
   assign q_item.luma  = luma_prod[RECIP_SHIFT +: 8];

endmodule

>>> hdl/rlhs_fifo.sv
// ----------------------------------------------------------------------------
// rlhs_fifo
// short item queue between front and back
// ----------------------------------------------------------------------------
module rlhs_fifo
   import rlhs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   input  logic     pop,
   output item_type head,
   output logic     full,
   output logic     empty
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   assign wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
   assign rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

`include "assert_macros.svh"

   `ASSERT_NEVER(a_no_push_full, push && full, "queue push while full")
   `ASSERT_NEVER(a_no_pop_empty, pop && empty, "queue pop while empty")
   `ASSERT_ALWAYS(a_count_up, push && !pop |=> count_ff == $past(count_ff) + 1'b1, "lost push")

endmodule

>>> hdl/rlhs_div.sv
// ----------------------------------------------------------------------------
// rlhs_div
// shared restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module rlhs_div
   import rlhs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [DIVIDEND_W-1:0] dq_ff, dq_in;

   // partial remainder and dividend/quotient shift register advance together
   always_comb begin
      logic [DIVISOR_W:0]    trial;
      logic [DIVISOR_W-1:0]  rem;
      logic [DIVIDEND_W-1:0] dq;
      rem = rem_ff;
      dq  = dq_ff;
      for (int i = 0; i < DIV_RADIX; i++) begin
         trial = {rem, dq[DIVIDEND_W-1]};
         dq    = {dq[DIVIDEND_W-2:0], 1'b0};
         if (trial >= {1'b0, dsr_ff}) begin
            trial = trial - {1'b0, dsr_ff};
            dq[0] = 1'b1;
         end
         rem = trial[DIVISOR_W-1:0];
      end

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      dq_in   = dq_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
         dq_in   = div_req.dividend;
      end else if (busy_ff) begin
         rem_in = rem;
         dq_in  = dq;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      dq_ff  <= dq_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dq_ff;

endmodule

>>> hdl/rlhs_back.sv
// ----------------------------------------------------------------------------
// rlhs_back
// applies clear and measure items, stretches pixels on the shared divider
// ----------------------------------------------------------------------------
module rlhs_back
   import rlhs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  item_type    q_head,
   input  logic        q_empty,
   output logic        q_pop,
   output div_req_type div_req,
   input  div_rsp_type div_rsp,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_out_red,
   output logic [7:0]  rsp_out_green,
   output logic [7:0]  rsp_out_blue,
   output logic        rsp_passed_through
);

   back_state_type state_ff, state_in;
   logic [7:0]     low_ff, low_in;
   logic [7:0]     high_ff, high_in;
   item_type       item_ff, item_in;
   logic [7:0]     inew_ff, inew_in;
   logic [7:0]     res_red_ff, res_red_in;
   logic [7:0]     res_green_ff, res_green_in;
   logic [7:0]     res_blue_ff, res_blue_in;
   logic           res_pass_ff, res_pass_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic           rsp_pass_ff;
   logic           flat, zero_inew, out_free, load;
   logic [7:0]     q_sat, luma_off, span;

   assign flat      = (low_ff == high_ff);
   assign zero_inew = (high_ff < low_ff) || (q_head.luma <= low_ff);
   assign luma_off  = q_head.luma - low_ff;
   assign span      = high_ff - low_ff;
   assign q_sat     = (|div_rsp.quotient[DIVIDEND_W-1:8]) ? PIXEL_MAX
                                                          : div_rsp.quotient[7:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty && (q_head.cmd == CMD_STRETCH)) begin
               if (flat || zero_inew) begin
                  state_in = BK_RESULT;
               end else begin
                  state_in = BK_DIV_INEW;
               end
            end
         end
         BK_DIV_INEW: begin
            if (div_rsp.done) begin
               state_in = (q_sat == '0) ? BK_RESULT : BK_DIV_RED;
            end
         end
         BK_DIV_RED: begin
            if (div_rsp.done) state_in = BK_DIV_GREEN;
         end
         BK_DIV_GREEN: begin
            if (div_rsp.done) state_in = BK_DIV_BLUE;
         end
         BK_DIV_BLUE: begin
            if (div_rsp.done) state_in = BK_RESULT;
         end
         BK_RESULT: begin
            if (out_free) state_in = BK_IDLE;
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs and datapath
   always_comb begin
      q_pop        = 1'b0;
      div_req      = '0;
      load         = 1'b0;
      low_in       = low_ff;
      high_in      = high_ff;
      item_in      = item_ff;
      inew_in      = inew_ff;
      res_red_in   = res_red_ff;
      res_green_in = res_green_ff;
      res_blue_in  = res_blue_ff;
      res_pass_in  = res_pass_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               q_pop   = 1'b1;
               item_in = q_head;
               unique case (q_head.cmd)
                  CMD_CLEAR: begin
                     low_in  = PIXEL_MAX;
                     high_in = '0;
                  end
                  CMD_MEASURE: begin
                     if (q_head.luma < low_ff)  low_in  = q_head.luma;
                     if (q_head.luma > high_ff) high_in = q_head.luma;
                  end
                  CMD_STRETCH: begin
                     res_pass_in = flat;
                     if (flat) begin
                        res_red_in   = q_head.red;
                        res_green_in = q_head.green;
                        res_blue_in  = q_head.blue;
                     end else if (zero_inew) begin
                        res_red_in   = '0;
                        res_green_in = '0;
                        res_blue_in  = '0;
                     end else begin
                        // (luma - low) * 255 / (high - low)
                        div_req.start    = 1'b1;
                        div_req.dividend = {luma_off, 8'd0} - {8'd0, luma_off};
                        div_req.divisor  = span;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         BK_DIV_INEW: begin
            if (div_rsp.done) begin
               inew_in = q_sat;
               if (q_sat == '0) begin
                  res_red_in   = '0;
                  res_green_in = '0;
                  res_blue_in  = '0;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = {8'd0, item_ff.red} * {8'd0, q_sat};
                  div_req.divisor  = item_ff.luma;
               end
            end
         end
         BK_DIV_RED: begin
            if (div_rsp.done) begin
               res_red_in       = q_sat;
               div_req.start    = 1'b1;
               div_req.dividend = {8'd0, item_ff.green} * {8'd0, inew_ff};
               div_req.divisor  = item_ff.luma;
            end
         end
         BK_DIV_GREEN: begin
            if (div_rsp.done) begin
               res_green_in     = q_sat;
               div_req.start    = 1'b1;
               div_req.dividend = {8'd0, item_ff.blue} * {8'd0, inew_ff};
               div_req.divisor  = item_ff.luma;
            end
         end
         BK_DIV_BLUE: begin
            if (div_rsp.done) res_blue_in = q_sat;
         end
         BK_RESULT: begin
            load = out_free;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         low_ff       <= PIXEL_MAX;
         high_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         low_ff       <= low_in;
         high_ff      <= high_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      inew_ff      <= inew_in;
      res_red_ff   <= res_red_in;
      res_green_ff <= res_green_in;
      res_blue_ff  <= res_blue_in;
      res_pass_ff  <= res_pass_in;
      if (load) begin
         rsp_red_ff   <= res_red_ff;
         rsp_green_ff <= res_green_ff;
         rsp_blue_ff  <= res_blue_ff;
         rsp_pass_ff  <= res_pass_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_red        = rsp_red_ff;
   assign rsp_out_green      = rsp_green_ff;
   assign rsp_out_blue       = rsp_blue_ff;
   assign rsp_passed_through = rsp_pass_ff;

endmodule

>>> hdl/rgb_luma_histogram_stretch_core.sv
// stretch: a stretch word's result takes up to four passes of the shared divider
//    (range, then red, green, blue); flat-range and at-or-below-minimum words need
//    none, and zero gain from the range division skips the channel passes
// throughput: clear and measure words run one per cycle while the queue has room;
//    stretch words are handled one at a time; the queue hides short stalls
// reset: synchronous, clears luma minimum to 255, maximum to 0, empties queue and output
// ----------------------------------------------------------------------------
// rgb_luma_histogram_stretch_core
// two-pass linear luma stretch: measure words track min/max luma, stretch
// words rescale each channel by the stretched-to-original luma ratio
// ----------------------------------------------------------------------------
module rgb_luma_histogram_stretch_core
   import rlhs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [7:0] req_red,
   input  logic [7:0] req_green,
   input  logic [7:0] req_blue,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_red,
   output logic [7:0] rsp_out_green,
   output logic [7:0] rsp_out_blue,
   output logic       rsp_passed_through
);

   // front to queue
   logic        q_push;
   item_type    q_item;
   logic        q_full;

   // queue to back
   item_type    q_head;
   logic        q_empty;
   logic        q_pop;

   // back to shared divider
   div_req_type div_req;
   div_rsp_type div_rsp;

   // front: registers the weighted channel sum, luma comes from a reciprocal
   // multiply on the way into the queue; unused command codes die here
   rlhs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_command (req_command),
      .req_red     (req_red),
      .req_green   (req_green),
      .req_blue    (req_blue),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_item      (q_item)
   );

   // decouples intake from the long stretch sequence
   rlhs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .full      (q_full),
      .empty     (q_empty)
   );

   // back: owns the luma statistics, so stretch words see every earlier
   // measure word in order; holds the output word register
   rlhs_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_head             (q_head),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .div_req            (div_req),
      .div_rsp            (div_rsp),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_red        (rsp_out_red),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_passed_through (rsp_passed_through)
   );

   // one divider serves the gain and all three channel scalings
   rlhs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luma histogram stretch core testbench
// feeds clear, measure, stretch and unused words with random gaps and result stalls,
// tracks min/max luma itself and checks every stretched pixel in order
// ----------------------------------------------------------------------------
module testbench
   import rlhs_pkg::*;
();

   localparam int RANDOM_WORDS = 905;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int SETTLE       = 60;
   localparam int SHOW_MAX     = 10;

   // one input word plus how it is to be sent
   typedef struct {
      cmd_type    cmd;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      int         gap;
      bit         drain;
   } word_type;

   // one stretched pixel as it should come back
   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       passed;
   } pixel_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_command = CMD_CLEAR;
   logic [7:0] req_red = 8'd0;
   logic [7:0] req_green = 8'd0;
   logic [7:0] req_blue = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_red;
   logic [7:0] rsp_out_green;
   logic [7:0] rsp_out_blue;
   logic       rsp_passed_through;

   word_type   pending_words[$];
   pixel_type  awaited_pixels[$];

   // own copy of the luma statistics
   logic [7:0] seen_luma_min;
   logic [7:0] seen_luma_max;

   int         cycle_count = 0;
   int         idle_cycles = 0;
   int         stall_left = 0;
   int         failures = 0;
   int         n_clear = 0;
   int         n_measure = 0;
   int         n_stretch = 0;
   int         n_unused = 0;
   int         n_results = 0;
   int         n_flat = 0;
   int         n_drains = 0;
   bit         burst_mode = 1'b0;
   bit         hold_for_drain = 1'b0;

   rgb_luma_histogram_stretch_core i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_red            (req_red),
      .req_green          (req_green),
      .req_blue           (req_blue),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_red        (rsp_out_red),
      .rsp_out_green      (rsp_out_green),
      .rsp_out_blue       (rsp_out_blue),
      .rsp_passed_through (rsp_passed_through)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // channel scaled by inew/luma, capped at full scale
   function automatic logic [7:0] scale_channel(input int chan, input int gain, input int luma);
      int v;
      if (luma == 0) begin
         return 8'd0;
      end
      v = (chan * gain) / luma;
      return (v > 255) ? PIXEL_MAX : 8'(v);
   endfunction

   // updates the luma statistics for one word and gives the stretched pixel,
   // returns 1 only when the word yields a result
   function automatic bit predict_stretch(input word_type w, output pixel_type px);
      int r;
      int g;
      int b;
      int luma;
      int lo;
      int hi;
      int gain;
      r    = int'(w.red);
      g    = int'(w.green);
      b    = int'(w.blue);
      luma = (299 * r + 587 * g + 114 * b) / 1000;
      lo   = int'(seen_luma_min);
      hi   = int'(seen_luma_max);
      px   = '{8'd0, 8'd0, 8'd0, 1'b0};
      case (w.cmd)
         CMD_CLEAR: begin
            seen_luma_min = PIXEL_MAX;
            seen_luma_max = 8'd0;
            return 1'b0;
         end
         CMD_MEASURE: begin
            if (luma < lo) seen_luma_min = 8'(luma);
            if (luma > hi) seen_luma_max = 8'(luma);
            return 1'b0;
         end
         CMD_STRETCH: begin
            // flat range: copy the pixel as it is
            if (lo == hi) begin
               px = '{w.red, w.green, w.blue, 1'b1};
               return 1'b1;
            end
            // inverted range or luma at/below the minimum gives zero gain
            if (hi < lo || luma <= lo) begin
               gain = 0;
            end else begin
               gain = ((luma - lo) * 255) / (hi - lo);
               if (gain > 255) gain = 255;
            end
            px = '{scale_channel(r, gain, luma), scale_channel(g, gain, luma),
                   scale_channel(b, gain, luma), 1'b0};
            return 1'b1;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   // queue one word, gap drawn unless a burst is being built
   task automatic queue_word(input cmd_type cmd, input logic [7:0] r, input logic [7:0] g,
                             input logic [7:0] b);
      word_type w;
      w.cmd   = cmd;
      w.red   = r;
      w.green = g;
      w.blue  = b;
      w.gap   = burst_mode ? 0 : int'($urandom_range(0, 19));
      w.drain = hold_for_drain;
      hold_for_drain = 1'b0;
      pending_words.push_back(w);
   endtask

   // channel value scattered around a base level, clamped to 0..255
   function automatic logic [7:0] jitter(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   function automatic logic [7:0] any_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // ---------------------------------------------------------------------------
   // driver: presents the head of the pending queue after its gap; a word
   // flagged for draining is held back until every stretched pixel is back
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_type px;
      if (reset) begin
         req_valid     <= 1'b0;
         idle_cycles   = 0;
         seen_luma_min = PIXEL_MAX;
         seen_luma_max = 8'd0;
      end else begin
         if (req_valid && !req_stall) begin
            // word taken at this edge
            case (pending_words[0].cmd)
               CMD_CLEAR:   n_clear++;
               CMD_MEASURE: n_measure++;
               CMD_STRETCH: n_stretch++;
               default:     n_unused++;
            endcase
            if (pending_words[0].drain) n_drains++;
            if (predict_stretch(pending_words[0], px)) awaited_pixels.push_back(px);
            pending_words.pop_front();
            idle_cycles = 0;
         end
         if (!req_valid || !req_stall) begin
            if (pending_words.size() != 0 && idle_cycles >= pending_words[0].gap &&
                !(pending_words[0].drain && awaited_pixels.size() != 0)) begin
               req_valid   <= 1'b1;
               req_command <= pending_words[0].cmd;
               req_red     <= pending_words[0].red;
               req_green   <= pending_words[0].green;
               req_blue    <= pending_words[0].blue;
            end else begin
               req_valid <= 1'b0;
               idle_cycles++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // monitor: checks each taken pixel against the oldest one awaited, and
   // draws a stall length for the next pixel; some stretches run stall-free
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_type want;
      bit        bad;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_results++;
            if (awaited_pixels.size() == 0) begin
               failures++;
               if (failures <= SHOW_MAX)
                  $display("%0t: pixel with nothing awaited: r=%0d g=%0d b=%0d pass=%0b",
                           $realtime, rsp_out_red, rsp_out_green, rsp_out_blue,
                           rsp_passed_through);
            end else begin
               want = awaited_pixels.pop_front();
               if (want.passed) n_flat++;
               bad = (rsp_out_red !== want.red) || (rsp_out_green !== want.green) ||
                     (rsp_out_blue !== want.blue) || (rsp_passed_through !== want.passed);
               if (bad) begin
                  failures++;
                  if (failures <= SHOW_MAX)
                     $display("%0t: pixel %0d want %0d %0d %0d %0b, got %0d %0d %0d %0b",
                              $realtime, n_results, want.red, want.green, want.blue,
                              want.passed, rsp_out_red, rsp_out_green, rsp_out_blue,
                              rsp_passed_through);
               end
            end
            stall_left = ((n_results % 160) < 32) ? 0 : int'($urandom_range(0, 19));
         end else if (rsp_valid && rsp_stall && stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left > 0);
      end
   end

   initial begin
      reset <= 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timeout after %0d cycles, %0d words left, %0d pixels awaited",
               cycle_count, pending_words.size(), awaited_pixels.size());
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // stimulus, then wait for the block to drain and report
   // ---------------------------------------------------------------------------
   initial begin
      int queued;
      int kind;
      int base;
      int spread;
      int n;
      int k;
      cmd_type c;

      // directed: stretch straight out of reset sees an inverted range
      queue_word(CMD_STRETCH, 8'd100, 8'd150, 8'd200);
      queue_word(CMD_UNUSED, 8'hFF, 8'hFF, 8'hFF);
      // one measure gives a flat range, pixel passes through
      queue_word(CMD_MEASURE, 8'd128, 8'd128, 8'd128);
      queue_word(CMD_STRETCH, 8'd10, 8'd200, 8'd30);
      // full range, black and white extremes, pure primaries
      queue_word(CMD_MEASURE, 8'd0, 8'd0, 8'd0);
      queue_word(CMD_MEASURE, 8'hFF, 8'hFF, 8'hFF);
      queue_word(CMD_STRETCH, 8'd0, 8'd0, 8'd0);
      queue_word(CMD_STRETCH, 8'hFF, 8'hFF, 8'hFF);
      queue_word(CMD_STRETCH, 8'hFF, 8'd0, 8'd0);
      queue_word(CMD_STRETCH, 8'd0, 8'hFF, 8'd0);
      queue_word(CMD_STRETCH, 8'd0, 8'd0, 8'hFF);
      queue_word(CMD_STRETCH, 8'd1, 8'd1, 8'd1);
      // narrow range 60..80: below, above, capped channel, middle, at minimum
      queue_word(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
      queue_word(CMD_MEASURE, 8'd60, 8'd60, 8'd60);
      queue_word(CMD_MEASURE, 8'd80, 8'd80, 8'd80);
      queue_word(CMD_STRETCH, 8'd20, 8'd20, 8'd20);
      queue_word(CMD_STRETCH, 8'd200, 8'd200, 8'd200);
      queue_word(CMD_STRETCH, 8'hFF, 8'd0, 8'd0);
      queue_word(CMD_STRETCH, 8'd70, 8'd70, 8'd70);
      queue_word(CMD_UNUSED, 8'd5, 8'd250, 8'd5);
      queue_word(CMD_STRETCH, 8'd60, 8'd60, 8'd60);
      // clear then stretch with nothing measured
      queue_word(CMD_CLEAR, 8'hAA, 8'h55, 8'hAA);
      queue_word(CMD_STRETCH, 8'd5, 8'd5, 8'd5);
      // sender holds off here until every pixel so far is back
      hold_for_drain = 1'b1;
      queue_word(CMD_MEASURE, 8'd90, 8'd40, 8'd220);

      // random: mostly clear/measure/stretch passes, some noise and odd orders
      queued = 0;
      while (queued < RANDOM_WORDS) begin
         kind       = $urandom_range(0, 9);
         burst_mode = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 29) == 0) hold_for_drain = 1'b1;
         if (kind <= 6) begin
            base = $urandom_range(0, 255);
            case ($urandom_range(0, 3))
               0:       spread = 0;
               1:       spread = 4;
               2:       spread = 24;
               default: spread = 128;
            endcase
            if ($urandom_range(0, 4) != 0) begin
               queue_word(CMD_CLEAR, any_byte(), any_byte(), any_byte());
               queued++;
            end
            n = $urandom_range(1, 8);
            for (k = 0; k < n; k++) begin
               queue_word(CMD_MEASURE, jitter(base, spread), jitter(base, spread),
                          jitter(base, spread));
               queued++;
            end
            n = $urandom_range(1, 10);
            for (k = 0; k < n; k++) begin
               if ($urandom_range(0, 3) == 0)
                  queue_word(CMD_STRETCH, any_byte(), any_byte(), any_byte());
               else
                  queue_word(CMD_STRETCH, jitter(base, spread + 10),
                             jitter(base, spread + 10), jitter(base, spread + 10));
               queued++;
            end
         end else if (kind == 7) begin
            n = $urandom_range(1, 6);
            for (k = 0; k < n; k++) begin
               c = cmd_type'($urandom_range(0, 3));
               queue_word(c, any_byte(), any_byte(), any_byte());
               if (c != CMD_UNUSED) queued++;
            end
         end else if (kind == 8) begin
            // stretch with nothing measured, or measures never stretched
            if ($urandom_range(0, 1) == 0) begin
               queue_word(CMD_CLEAR, any_byte(), any_byte(), any_byte());
               queue_word(CMD_STRETCH, any_byte(), any_byte(), any_byte());
               queued += 2;
            end else begin
               n = $urandom_range(1, 4);
               for (k = 0; k < n; k++) begin
                  queue_word(CMD_MEASURE, any_byte(), any_byte(), any_byte());
                  queued++;
               end
               queue_word(CMD_UNUSED, any_byte(), any_byte(), any_byte());
            end
         end else begin
            queue_word(CMD_STRETCH, any_byte(), any_byte(), any_byte());
            queued++;
         end
      end
      burst_mode = 1'b0;

      // wait for all words to be taken, then for the last pixels
      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (awaited_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("sent %0d clear, %0d measure, %0d stretch and %0d unused words, %0d drain holds",
               n_clear, n_measure, n_stretch, n_unused, n_drains);
      $display("checked %0d pixels, %0d of them flat-range copies, %0d failures in %0d cycles",
               n_results, n_flat, failures, cycle_count);
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hdl
hdl/rlhs_pkg.sv
hdl/rlhs_front.sv
hdl/rlhs_fifo.sv
hdl/rlhs_div.sv
hdl/rlhs_back.sv
hdl/rgb_luma_histogram_stretch_core.sv
tb/sv/testbench.sv
